/* src/pcd_pkg.sv */
// ----------------------------------------------------------------------------
// pcd_pkg
// Shared constants and types of the particle charge deposition core.
// ----------------------------------------------------------------------------
package pcd_pkg;

    localparam int GRID_SIZE = 32;
    localparam int CELL_W    = 5;
    localparam int CELLS     = GRID_SIZE * GRID_SIZE * GRID_SIZE;
    localparam int ADDR_W    = 3 * CELL_W;
    localparam int FRAC_W    = 16;
    localparam int POS_W     = 21;
    localparam int PW_W      = 24;
    localparam int CHG_W     = 8;
    localparam int DENS_W    = 32;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 2;
    localparam int WGT_W     = FRAC_W + 1;

    localparam logic [WGT_W-1:0] ONE_Q16 = WGT_W'(65536);

    localparam logic [CFG_IDX_W-1:0] CFG_DIMENSION     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_CENTERED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_SCALE  = 2'd2;

    localparam logic CMD_DEPOSIT = 1'b0;
    localparam logic CMD_READ    = 1'b1;

    typedef struct packed {
        logic              load;
        logic              prep;
        logic              mul_xy;
        logic              mul_z;
        logic              mul_c;
        logic              mul_q;
        logic              mem_rd;
        logic              wr_sum;
        logic              out_load;
        logic              clr_wr;
        logic [2:0]        corner;
        logic [ADDR_W-1:0] clr_addr;
    } t_dp_cmd;

    typedef struct packed {
        logic skip;
        logic out_free;
    } t_dp_sts;

endpackage

/* src/pcd_ctrl.sv */
// ----------------------------------------------------------------------------
// pcd_ctrl
// Sequencer: grid clearing pass, corner walk of a deposit, read and clear.
// ----------------------------------------------------------------------------
module pcd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_command,
    input  pcd_pkg::t_dp_sts i_sts,
    output logic             o_in_stall,
    output pcd_pkg::t_dp_cmd o_cmd
);
    import pcd_pkg::*;

    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_PREP   = 4'd2;
    localparam logic [3:0] S_CORNER = 4'd3;
    localparam logic [3:0] S_MW     = 4'd4;
    localparam logic [3:0] S_MM     = 4'd5;
    localparam logic [3:0] S_MQ     = 4'd6;
    localparam logic [3:0] S_WR     = 4'd7;
    localparam logic [3:0] S_RDA    = 4'd8;
    localparam logic [3:0] S_RDO    = 4'd9;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);

    logic [3:0]        r_state, n_state;
    logic [2:0]        r_idx, n_idx;
    logic [ADDR_W-1:0] r_clr, n_clr;
    logic              accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_clr   = r_clr;
        o_cmd   = '0;
        o_cmd.corner   = r_idx;
        o_cmd.clr_addr = r_clr;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                n_clr = r_clr + 1'b1;
                if (r_clr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                n_idx = '0;
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_state = (i_command == CMD_READ) ? S_RDA : S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state = S_CORNER;
            end
            S_CORNER: begin
                if (i_sts.skip) begin
                    n_idx = r_idx + 1'b1;
                    if (r_idx == 3'd7) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    o_cmd.mul_xy = 1'b1;
                    o_cmd.mem_rd = 1'b1;
                    n_state = S_MW;
                end
            end
            S_MW: begin
                o_cmd.mul_z = 1'b1;
                n_state = S_MM;
            end
            S_MM: begin
                o_cmd.mul_c = 1'b1;
                n_state = S_MQ;
            end
            S_MQ: begin
                o_cmd.mul_q = 1'b1;
                n_state = S_WR;
            end
            S_WR: begin
                o_cmd.wr_sum = 1'b1;
                n_idx = r_idx + 1'b1;
                n_state = (r_idx == 3'd7) ? S_IDLE : S_CORNER;
            end
            S_RDA: begin
                o_cmd.mem_rd = 1'b1;
                n_state = S_RDO;
            end
            S_RDO: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_idx   <= '0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_clr   <= n_clr;
        end
    end

endmodule

/* src/pcd_datapath.sv */
// ----------------------------------------------------------------------------
// pcd_datapath
// Configuration registers, weight arithmetic, density grid memory and
// output register.
// ----------------------------------------------------------------------------
module pcd_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [pcd_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [pcd_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic [pcd_pkg::CELL_W-1:0]           i_cell_x,
    input  logic [pcd_pkg::CELL_W-1:0]           i_cell_y,
    input  logic [pcd_pkg::CELL_W-1:0]           i_cell_z,
    input  logic [pcd_pkg::FRAC_W-1:0]           i_frac_x,
    input  logic [pcd_pkg::FRAC_W-1:0]           i_frac_y,
    input  logic [pcd_pkg::FRAC_W-1:0]           i_frac_z,
    input  logic [pcd_pkg::POS_W-1:0]            i_old_pos_x,
    input  logic [pcd_pkg::POS_W-1:0]            i_old_pos_y,
    input  logic [pcd_pkg::POS_W-1:0]            i_old_pos_z,
    input  logic [pcd_pkg::PW_W-1:0]             i_particle_weight,
    input  logic signed [pcd_pkg::CHG_W-1:0]     i_particle_charge,
    input  logic                                 i_out_stall,
    input  pcd_pkg::t_dp_cmd                     i_cmd,
    output pcd_pkg::t_dp_sts                     o_sts,
    output logic                                 o_out_valid,
    output logic signed [pcd_pkg::DENS_W-1:0]    o_density_value
);
    import pcd_pkg::*;

    localparam int AMT_W = 2 * FRAC_W + 2 + CHG_W + 2;
    localparam int SUM_W = AMT_W + 1;
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(64'sd2147483648);

    logic [1:0]              r_dim;
    logic                    r_tc;
    logic [CFG_W-1:0]        r_scale;
    logic                    r_out_valid;
    logic [DENS_W-1:0]       r_out_data;

    logic [CELL_W-1:0]       r_cx, r_cy, r_cz;
    logic [FRAC_W-1:0]       r_fx, r_fy, r_fz;
    logic [POS_W-1:0]        r_ox, r_oy, r_oz;
    logic [PW_W-1:0]         r_pw;
    logic signed [CHG_W-1:0] r_charge;

    logic [WGT_W-1:0]        r_wx0, r_wx1, r_wy0, r_wy1, r_wz0, r_wz1;
    logic [DENS_W-1:0]       r_coef;
    logic [WGT_W-1:0]        r_wxy, r_w;
    logic [2*FRAC_W:0]       r_m;
    logic signed [AMT_W-1:0] r_amt;
    logic [DENS_W-1:0]       r_rd_data;

    logic [DENS_W-1:0]       mem [CELLS];

    logic                    dim3, y_act, z_act;
    logic [POS_W:0]          sum_x, sum_y, sum_z;
    logic [FRAC_W-1:0]       fx, fy, fz;
    logic [2*PW_W-1:0]       prod_c;
    logic [WGT_W-1:0]        wx_s, wy_s, wz_s;
    logic [2*WGT_W-1:0]      prod_xy, prod_z;
    logic [WGT_W+DENS_W-1:0] prod_m;
    logic signed [AMT_W-1:0] prod_q;
    logic [CELL_W:0]         ex, ey, ez;
    logic                    in_grid;
    logic [ADDR_W-1:0]       addr;
    logic signed [SUM_W-1:0] sum;
    logic [DENS_W-1:0]       sat;
    logic                    wr_en;
    logic [DENS_W-1:0]       wr_data;

    assign dim3  = (r_dim == 2'd0) || (r_dim == 2'd3);
    assign y_act = (r_dim != 2'd1);
    assign z_act = dim3;

    assign sum_x = {1'b0, r_cx, r_fx} + {1'b0, r_ox};
    assign sum_y = {1'b0, r_cy, r_fy} + {1'b0, r_oy};
    assign sum_z = {1'b0, r_cz, r_fz} + {1'b0, r_oz};
    assign fx    = r_tc ? sum_x[FRAC_W:1] : r_fx;
    assign fy    = r_tc ? sum_y[FRAC_W:1] : r_fy;
    assign fz    = r_tc ? sum_z[FRAC_W:1] : r_fz;

    assign prod_c  = r_scale * r_pw;
    assign wx_s    = i_cmd.corner[2] ? r_wx1 : r_wx0;
    assign wy_s    = i_cmd.corner[1] ? r_wy1 : r_wy0;
    assign wz_s    = i_cmd.corner[0] ? r_wz1 : r_wz0;
    assign prod_xy = wx_s * wy_s;
    assign prod_z  = r_wxy * wz_s;
    assign prod_m  = r_w * r_coef;
    assign prod_q  = $signed({1'b0, r_m}) * r_charge;

    assign ex      = {1'b0, r_cx} + {{CELL_W{1'b0}}, i_cmd.corner[2]};
    assign ey      = {1'b0, r_cy} + {{CELL_W{1'b0}}, i_cmd.corner[1]};
    assign ez      = {1'b0, r_cz} + {{CELL_W{1'b0}}, i_cmd.corner[0]};
    assign in_grid = (ex < (CELL_W+1)'(GRID_SIZE)) && (ey < (CELL_W+1)'(GRID_SIZE))
                  && (ez < (CELL_W+1)'(GRID_SIZE));
    assign addr    = i_cmd.clr_wr ? i_cmd.clr_addr
                                  : {ex[CELL_W-1:0], ey[CELL_W-1:0], ez[CELL_W-1:0]};

    assign sum = SUM_W'($signed(r_rd_data)) + SUM_W'(r_amt);
    always_comb begin
        if (sum > SAT_HI) begin
            sat = {1'b0, {(DENS_W-1){1'b1}}};
        end else if (sum < SAT_LO) begin
            sat = {1'b1, {(DENS_W-1){1'b0}}};
        end else begin
            sat = sum[DENS_W-1:0];
        end
    end

    assign wr_en   = i_cmd.clr_wr || ((i_cmd.wr_sum || i_cmd.out_load) && in_grid);
    assign wr_data = i_cmd.wr_sum ? sat : '0;

    assign o_sts.skip     = ((r_dim == 2'd1) && (i_cmd.corner[1] || i_cmd.corner[0]))
                         || ((r_dim == 2'd2) && i_cmd.corner[0]);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid     = r_out_valid;
    assign o_density_value = $signed(r_out_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim       <= 2'd3;
            r_tc        <= 1'b0;
            r_scale     <= CFG_W'(65536);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_DIMENSION:     r_dim   <= i_cfg_data[1:0];
                    CFG_TIME_CENTERED: r_tc    <= i_cfg_data[0];
                    CFG_CHARGE_SCALE:  r_scale <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cx     <= i_cell_x;
            r_cy     <= i_cell_y;
            r_cz     <= i_cell_z;
            r_fx     <= i_frac_x;
            r_fy     <= i_frac_y;
            r_fz     <= i_frac_z;
            r_ox     <= i_old_pos_x;
            r_oy     <= i_old_pos_y;
            r_oz     <= i_old_pos_z;
            r_pw     <= i_particle_weight;
            r_charge <= i_particle_charge;
        end
        if (i_cmd.prep) begin
            r_wx0  <= ONE_Q16 - {1'b0, fx};
            r_wx1  <= {1'b0, fx};
            r_wy0  <= y_act ? (ONE_Q16 - {1'b0, fy}) : ONE_Q16;
            r_wy1  <= y_act ? {1'b0, fy} : '0;
            r_wz0  <= z_act ? (ONE_Q16 - {1'b0, fz}) : ONE_Q16;
            r_wz1  <= z_act ? {1'b0, fz} : '0;
            r_coef <= prod_c[2*PW_W-1:FRAC_W];
        end
        if (i_cmd.mul_xy) begin
            r_wxy <= prod_xy[2*FRAC_W:FRAC_W];
        end
        if (i_cmd.mul_z) begin
            r_w <= prod_z[2*FRAC_W:FRAC_W];
        end
        if (i_cmd.mul_c) begin
            r_m <= prod_m[WGT_W+DENS_W-1:FRAC_W];
        end
        if (i_cmd.mul_q) begin
            r_amt <= prod_q;
        end
        if (i_cmd.out_load) begin
            r_out_data <= in_grid ? r_rd_data : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
        if (i_cmd.mem_rd) begin
            r_rd_data <= mem[addr];
        end
    end

endmodule

/* src/particle_charge_deposition_core.sv */
// ----------------------------------------------------------------------------
// particle_charge_deposition_core
// Cloud-in-cell charge deposition onto a 32x32x32 Q16.16 density grid.
// ----------------------------------------------------------------------------
// After reset the core clears all 32768 grid cells, one cell a cycle, with
// o_in_stall high; configuration writes are taken during that time. A deposit
// beat does, for each of its N active corners (2, 4 or 8), one
// read-modify-write of the single-port grid memory behind a chain of four
// registered multiplies; no new beat is accepted until its last corner is
// written. A read-and-clear beat reads the cell, waits while the output
// register is still stalled, then loads it and clears the cell.
module particle_charge_deposition_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [pcd_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [pcd_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_command,
    input  logic [pcd_pkg::CELL_W-1:0]           i_cell_x,
    input  logic [pcd_pkg::CELL_W-1:0]           i_cell_y,
    input  logic [pcd_pkg::CELL_W-1:0]           i_cell_z,
    input  logic [pcd_pkg::FRAC_W-1:0]           i_frac_x,
    input  logic [pcd_pkg::FRAC_W-1:0]           i_frac_y,
    input  logic [pcd_pkg::FRAC_W-1:0]           i_frac_z,
    input  logic [pcd_pkg::POS_W-1:0]            i_old_pos_x,
    input  logic [pcd_pkg::POS_W-1:0]            i_old_pos_y,
    input  logic [pcd_pkg::POS_W-1:0]            i_old_pos_z,
    input  logic [pcd_pkg::PW_W-1:0]             i_particle_weight,
    input  logic signed [pcd_pkg::CHG_W-1:0]     i_particle_charge,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [pcd_pkg::DENS_W-1:0]    o_density_value
);
    import pcd_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    pcd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    pcd_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_cell_x          (i_cell_x),
        .i_cell_y          (i_cell_y),
        .i_cell_z          (i_cell_z),
        .i_frac_x          (i_frac_x),
        .i_frac_y          (i_frac_y),
        .i_frac_z          (i_frac_z),
        .i_old_pos_x       (i_old_pos_x),
        .i_old_pos_y       (i_old_pos_y),
        .i_old_pos_z       (i_old_pos_z),
        .i_particle_weight (i_particle_weight),
        .i_particle_charge (i_particle_charge),
        .i_out_stall       (i_out_stall),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .o_out_valid       (o_out_valid),
        .o_density_value   (o_density_value)
    );

endmodule

/* src/pcd_checker.sv */
// ----------------------------------------------------------------------------
// pcd_checker
// Port-level checks of the particle charge deposition core.
// ----------------------------------------------------------------------------
module pcd_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic signed [pcd_pkg::DENS_W-1:0] o_density_value
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_density_value))
        else $error("output payload changed while stalled");

    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall && !o_out_valid)
        else $error("core not busy clearing after reset");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall && !$rose(o_out_valid))
        else $error("core idle or result too early after accepted beat");

endmodule

bind particle_charge_deposition_core pcd_checker u_pcd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_density_value (o_density_value)
);
